### rtl/ste_pkg.sv
// shared types and constants for the sprite tile expander
package ste_pkg;

  localparam int unsigned MaxTilesPerAxis = 8;
  localparam int unsigned AxisW           = $clog2(MaxTilesPerAxis);

  localparam int unsigned InDataW  = 72;
  localparam int unsigned OutDataW = 64;
  localparam int unsigned PosW     = 11;
  localparam int unsigned CodeW    = 17;
  localparam int unsigned IdxW     = CodeW + 1;
  localparam int unsigned ScaleW   = 6;
  localparam int unsigned CfgDimW  = 9;
  localparam int unsigned PaddrW   = 4;

  localparam logic [ScaleW-1:0] ScaleUnity = 6'd32;

  // register indexes on the configuration port
  localparam logic [1:0] RegFlipScreen   = 2'd0;
  localparam logic [1:0] RegScreenWidth  = 2'd1;
  localparam logic [1:0] RegScreenHeight = 2'd2;

  localparam logic [CfgDimW-1:0] ScreenWidthRst  = 9'd320;
  localparam logic [CfgDimW-1:0] ScreenHeightRst = 9'd224;

  typedef enum logic [1:0] {
    StIdle,
    StSetup,
    StRun
  } state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic emit;
  } ctrl_t;

  typedef struct packed {
    logic last_tile;
  } status_t;

endpackage

### rtl/ste_ctrl.sv
// controller state machine for the sprite tile expander
module ste_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            s_valid_i,
  input  logic            m_ready_i,
  input  ste_pkg::status_t status_i,
  output ste_pkg::ctrl_t   ctrl_o,
  output logic            s_ready_o,
  output logic            m_valid_o
);

  ste_pkg::state_e state_q, state_d;
  logic            m_valid_q, m_valid_d;
  logic            slot_free;

  assign slot_free = !m_valid_q || m_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ste_pkg::StIdle: begin
        if (s_valid_i) state_d = ste_pkg::StSetup;
      end
      ste_pkg::StSetup: begin
        state_d = ste_pkg::StRun;
      end
      ste_pkg::StRun: begin
        if (slot_free && status_i.last_tile) state_d = ste_pkg::StIdle;
      end
      default: state_d = ste_pkg::StIdle;
    endcase
  end

  always_comb begin
    ctrl_o    = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      ste_pkg::StIdle: begin
        s_ready_o   = 1'b1;
        ctrl_o.load = s_valid_i;
      end
      ste_pkg::StSetup: begin
        ctrl_o.setup = 1'b1;
      end
      ste_pkg::StRun: begin
        ctrl_o.emit = slot_free;
      end
      default: ;
    endcase
  end

  // output register occupancy
  always_comb begin
    m_valid_d = m_valid_q;
    if (ctrl_o.emit) m_valid_d = 1'b1;
    else if (m_ready_i) m_valid_d = 1'b0;
  end

  assign m_valid_o = m_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ste_pkg::StIdle;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      m_valid_q <= m_valid_d;
    end
  end

endmodule

### rtl/ste_dp.sv
// datapath: sprite decode, origin setup, tile walk and output register
module ste_dp #(
  parameter int unsigned LUT_ENTRIES = 65536
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  ste_pkg::ctrl_t                   ctrl_i,
  output ste_pkg::status_t                 status_o,
  input  logic [ste_pkg::InDataW-1:0]      s_data_i,
  input  logic                             flip_screen_i,
  input  logic [ste_pkg::CfgDimW-1:0]      screen_width_i,
  input  logic [ste_pkg::CfgDimW-1:0]      screen_height_i,
  output logic [ste_pkg::OutDataW-1:0]     m_data_o,
  output logic                             m_last_o
);

  localparam logic [ste_pkg::IdxW-1:0] LutMask = ste_pkg::IdxW'(LUT_ENTRIES - 1);

  // captured record, payload only
  logic [15:0]                 yw_q, xw_q, attr_q;
  logic [ste_pkg::PosW-1:0]    x0_q, y0_q;
  logic [ste_pkg::OutDataW-1:0] data_q;
  logic                        last_q;

  // walk control
  logic [ste_pkg::AxisW-1:0]   row_q, row_d, col_q, col_d;
  logic [ste_pkg::IdxW-1:0]    idx_q, idx_d;

  logic [2:0]                  nxm1, nym1;
  logic [3:0]                  nx, ny, zx, zy;
  logic [ste_pkg::ScaleW-1:0]  sx, sy;
  logic                        fx, fy;
  logic [ste_pkg::PosW-1:0]    posx, posy, x0, y0, xo, yo;
  logic [7:0]                  nzx, nzy, nzx2, nzy2;
  logic [8:0]                  spanx, spany;
  logic [ste_pkg::AxisW-1:0]   dx, dy;
  logic [8:0]                  offx, offy;
  logic [ste_pkg::PosW-1:0]    tx, ty;
  logic [ste_pkg::IdxW-1:0]    idx_m;
  logic                        col_end, row_end;

  assign nxm1 = xw_q[11:9];
  assign nym1 = yw_q[11:9];
  assign nx   = {1'b0, nxm1} + 4'd1;
  assign ny   = {1'b0, nym1} + 4'd1;
  assign zx   = xw_q[15:12];
  assign zy   = yw_q[15:12];
  assign sx   = ste_pkg::ScaleUnity - {2'b00, zx};
  assign sy   = ste_pkg::ScaleUnity - {2'b00, zy};
  assign fx   = attr_q[14] ^ flip_screen_i;
  assign fy   = attr_q[15] ^ flip_screen_i;

  // x wraps at 0x180, y is plain two's complement
  assign posx = (xw_q[8] & xw_q[7]) ? {2'b11, xw_q[8:0]} : {2'b00, xw_q[8:0]};
  assign posy = {{2{yw_q[8]}}, yw_q[8:0]};

  // centre by zoom: (n * zoom + 2) / 4
  assign nzx  = 8'(nx) * 8'(zx);
  assign nzy  = 8'(ny) * 8'(zy);
  assign nzx2 = nzx + 8'd2;
  assign nzy2 = nzy + 8'd2;
  assign x0   = posx + ste_pkg::PosW'(nzx2[7:2]);
  assign y0   = posy + ste_pkg::PosW'(nzy2[7:2]);

  assign spanx = 9'(nx) * 9'(sx);
  assign spany = 9'(ny) * 9'(sy);
  assign xo = flip_screen_i
            ? ste_pkg::PosW'(screen_width_i) - x0 - ste_pkg::PosW'(spanx[8:1]) : x0;
  assign yo = flip_screen_i
            ? ste_pkg::PosW'(screen_height_i) - y0 - ste_pkg::PosW'(spany[8:1]) : y0;

  // per-tile position, axes run backwards when flipped
  assign dx   = fx ? (nxm1 - col_q) : col_q;
  assign dy   = fy ? (nym1 - row_q) : row_q;
  assign offx = 9'(dx) * 9'(sx);
  assign offy = 9'(dy) * 9'(sy);
  assign tx   = x0_q + ste_pkg::PosW'(offx[8:1]);
  assign ty   = y0_q + ste_pkg::PosW'(offy[8:1]);

  assign idx_m   = idx_q & LutMask;
  assign col_end = (col_q == nxm1);
  assign row_end = (row_q == nym1);
  assign status_o.last_tile = col_end && row_end;

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    idx_d = idx_q;
    if (ctrl_i.load) begin
      row_d = '0;
      col_d = '0;
      idx_d = {1'b0, s_data_i[64:48]};
    end else if (ctrl_i.emit) begin
      idx_d = idx_q + 1'b1;
      if (col_end) begin
        col_d = '0;
        row_d = row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      idx_q <= '0;
    end else begin
      row_q <= row_d;
      col_q <= col_d;
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      yw_q   <= s_data_i[15:0];
      xw_q   <= s_data_i[31:16];
      attr_q <= s_data_i[47:32];
    end
    if (ctrl_i.setup) begin
      x0_q <= xo;
      y0_q <= yo;
    end
    if (ctrl_i.emit) begin
      data_q <= {2'b00, sy, sx, attr_q[7:6], attr_q[15:8], fy, fx, ty, tx, idx_m[15:0]};
      last_q <= status_o.last_tile;
    end
  end

  assign m_data_o = data_q;
  assign m_last_o = last_q;

endmodule

### rtl/sprite_tile_expander_core.sv
// sprite tile expander top level: stream ports, register port, assertions
// after a record is taken, the setup state registers the sprite origin, then the run state
// emits one tile a cycle from the tile walk counters into the output register, pausing
//   while the output register is full and m_axis_tready is low
// the next record is taken once the final tile has entered the output register
// reset: asynchronous, clears the state machine, output valid and the registers
//   (flip_screen 0, screen_width 320, screen_height 224)
module sprite_tile_expander_core #(
  parameter int unsigned LUT_ENTRIES = 65536
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // y_word[15:0], x_word[31:16], attr_word[47:32], base_code[64:48], zeros
  input  logic [ste_pkg::InDataW-1:0]     s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // lut_index[15:0], tile_x[26:16], tile_y[37:27], mirror_x[38], mirror_y[39],
  // colour[47:40], prio_select[49:48], scale_x[55:50], scale_y[61:56], zeros
  output logic [ste_pkg::OutDataW-1:0]    m_axis_tdata,
  output logic                            m_axis_tlast,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ste_pkg::PaddrW-1:0]      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  ste_pkg::ctrl_t   ctrl;
  ste_pkg::status_t status;

  logic                         flip_screen_q;
  logic [ste_pkg::CfgDimW-1:0]  screen_width_q, screen_height_q;
  logic                         cfg_wr;
  logic [1:0]                   reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flip_screen_q   <= 1'b0;
      screen_width_q  <= ste_pkg::ScreenWidthRst;
      screen_height_q <= ste_pkg::ScreenHeightRst;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        ste_pkg::RegFlipScreen:   flip_screen_q   <= pwdata[0];
        ste_pkg::RegScreenWidth:  screen_width_q  <= pwdata[8:0];
        ste_pkg::RegScreenHeight: screen_height_q <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ste_pkg::RegFlipScreen:   prdata = {31'd0, flip_screen_q};
      ste_pkg::RegScreenWidth:  prdata = {23'd0, screen_width_q};
      ste_pkg::RegScreenHeight: prdata = {23'd0, screen_height_q};
      default:                  prdata = '0;
    endcase
  end

  ste_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .status_i  (status),
    .ctrl_o    (ctrl),
    .s_ready_o (s_axis_tready),
    .m_valid_o (m_axis_tvalid)
  );

  ste_dp #(
    .LUT_ENTRIES (LUT_ENTRIES)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .status_o        (status),
    .s_data_i        (s_axis_tdata),
    .flip_screen_i   (flip_screen_q),
    .screen_width_i  (screen_width_q),
    .screen_height_i (screen_height_q),
    .m_data_o        (m_axis_tdata),
    .m_last_o        (m_axis_tlast)
  );

  // a taken record always leaves at least the setup cycle busy
  a_busy_after_request : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input taken again straight after a request");

  // no new record while tiles are still being walked
  a_no_take_while_emit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.emit |-> !s_axis_tready)
    else $error("input ready during tile walk");

  // emitting the final tile frees the input side and leaves the last tile valid on the output
  a_idle_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.emit && status.last_tile) |=> (s_axis_tready && m_axis_tvalid && m_axis_tlast))
    else $error("final tile did not end the walk");

endmodule
